### hw/rtl/chm_pkg.sv
// Shared types, codes and constants of the chained hash map.
`default_nettype none

package chm_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int TOTAL_BITS    = 11;
    localparam int INIT_LOG      = 2;
    localparam int GROW_FAST_LOG = 9;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_GET    = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_DUP      = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]            command;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] key_hash;
        logic [FIELD_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] value_out;
        logic [TOTAL_BITS-1:0] entry_total;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_NODE,
        ST_MISS,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_GROW_CHK,
        ST_G_HEAD,
        ST_G_HDAT,
        ST_G_NODE,
        ST_G_WRITE,
        ST_INS_RD,
        ST_INS_WR,
        ST_RESP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_HEAD,
        OP_STEP,
        OP_UNLINK,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_INC,
        OP_GROW_INIT,
        OP_G_HEAD,
        OP_G_HDAT,
        OP_G_NODE,
        OP_G_WRITE,
        OP_INS_RD,
        OP_INS_WR,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] code;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] command;
        logic       clr_done;
        logic       head_zero;
        logic       key_match;
        logic       link_zero;
        logic       cur_zero;
        logic       pool_full;
        logic       scan_at_hw;
        logic       used_bit;
        logic       grow_need;
        logic       wk_last;
        logic       gb_last;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/chm_datapath.sv
// Datapath of the chained hash map: bucket and node memories, pointers and result register.
`default_nettype none

module chm_datapath #(
    parameter int NODE_COUNT  = 1024,
    parameter int MAX_BUCKETS = 4096,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  wire                clk,
    input  wire                rst_n,
    input  chm_pkg::req_t      req,
    input  chm_pkg::ctrl_t     ctrl,
    output chm_pkg::dp_stat_t  stat,
    output logic               rsp_valid,
    input  wire                rsp_stall,
    output chm_pkg::rsp_t      rsp
);

    localparam int IW     = $clog2(NODE_COUNT);
    localparam int NW     = $clog2(NODE_COUNT + 1);
    localparam int LIMIT  = $clog2(MAX_BUCKETS + 1) - 1;
    localparam int BW     = LIMIT;
    localparam int BDEPTH = 1 << LIMIT;
    localparam int LW     = $clog2(LIMIT + 3);
    localparam int KB     = (KEY_BITS > chm_pkg::FIELD_BITS) ? chm_pkg::FIELD_BITS : KEY_BITS;
    localparam int VB     = (VALUE_BITS > chm_pkg::FIELD_BITS) ? chm_pkg::FIELD_BITS
                                                               : VALUE_BITS;
    localparam int CMPW   = (NW + 1 > LIMIT + 2) ? NW + 1 : LIMIT + 2;
    localparam int IB     = chm_pkg::INIT_LOG;

    // Memories.
    logic [NW-1:0] head_mem [BDEPTH];
    logic [KB-1:0] key_mem  [NODE_COUNT];
    logic [VB-1:0] val_mem  [NODE_COUNT];
    logic [BW-1:0] hash_mem [NODE_COUNT];
    logic [NW-1:0] link_mem [NODE_COUNT];
    logic          used_mem [NODE_COUNT];

    // Request and walk registers.
    logic [1:0]    cmd_reg;
    logic [KB-1:0] key_reg;
    logic [BW-1:0] hash_reg;
    logic [VB-1:0] value_reg;
    logic [NW-1:0] cur_reg;
    logic [NW-1:0] prev_reg;
    logic [NW-1:0] scan_reg;
    logic [NW-1:0] tmp_reg [4];

    // Control registers.
    logic [LW-1:0] log_reg;
    logic [LW-1:0] new_log_reg;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] hw_reg;
    logic [NW-1:0] free_low_reg;
    logic [IB-1:0] clr_reg;
    logic [BW-1:0] gb_reg;
    logic [1:0]    wk_reg;
    logic          out_valid_reg;
    chm_pkg::rsp_t out_reg;

    // Registered read data.
    logic [NW-1:0] head_rd_reg;
    logic [KB-1:0] rd_key_reg;
    logic [VB-1:0] rd_val_reg;
    logic [BW-1:0] rd_hash_reg;
    logic [NW-1:0] rd_link_reg;
    logic          used_rd_reg;

    logic [BW-1:0] log_mask;
    logic [BW-1:0] req_bucket;
    logic [BW-1:0] cur_bucket;
    logic [NW-1:0] cur_m1;
    logic [NW-1:0] prev_m1;
    logic [NW-1:0] head_m1;
    logic [NW-1:0] link_m1;
    logic [NW-1:0] scan_p1;
    logic [CMPW-1:0] twice_count;
    logic [CMPW-1:0] grow_bound;
    logic [LW-1:0] grow_sum;
    logic [LW-1:0] new_log_next;
    logic [1:0]    k_mask;
    logic [1:0]    k_idx;
    logic          out_free;

    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [NW-1:0] head_wd;
    logic          head_re;
    logic [BW-1:0] head_ra;
    logic          link_we;
    logic [IW-1:0] link_wa;
    logic [NW-1:0] link_wd;
    logic          node_re;
    logic [IW-1:0] node_ra;
    logic          used_we;
    logic [IW-1:0] used_wa;
    logic          used_wd;

    assign log_mask   = ~({BW{1'b1}} << log_reg);
    assign req_bucket = req.key_hash[BW-1:0] & log_mask;
    assign cur_bucket = hash_reg & log_mask;
    assign cur_m1     = cur_reg - NW'(1);
    assign prev_m1    = prev_reg - NW'(1);
    assign head_m1    = head_rd_reg - NW'(1);
    assign link_m1    = rd_link_reg - NW'(1);
    assign scan_p1    = scan_reg + NW'(1);

    assign twice_count = CMPW'(count_reg) << 1;
    assign grow_bound  = CMPW'(3) << log_reg;
    assign grow_sum    = (32'(log_reg) < chm_pkg::GROW_FAST_LOG) ? log_reg + LW'(2)
                                                                 : log_reg + LW'(1);
    assign new_log_next = (grow_sum > LW'(LIMIT)) ? LW'(LIMIT) : grow_sum;

    // Growth spreads one old bucket over two or four new ones.
    assign k_mask = ((new_log_reg - log_reg) == LW'(2)) ? 2'b11 : 2'b01;
    assign k_idx  = 2'(rd_hash_reg >> log_reg) & k_mask;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        stat.command    = cmd_reg;
        stat.clr_done   = (clr_reg == {IB{1'b1}});
        stat.head_zero  = (head_rd_reg == '0);
        stat.key_match  = (rd_key_reg == key_reg);
        stat.link_zero  = (rd_link_reg == '0);
        stat.cur_zero   = (cur_reg == '0);
        stat.pool_full  = (count_reg == NW'(NODE_COUNT));
        stat.scan_at_hw = (scan_reg >= hw_reg);
        stat.used_bit   = used_rd_reg;
        stat.grow_need  = (twice_count > grow_bound) && (log_reg < LW'(LIMIT));
        stat.wk_last    = (wk_reg == k_mask);
        stat.gb_last    = (gb_reg == log_mask);
        stat.out_free   = out_free;
    end

    // Memory port selection.
    always_comb
    begin
        head_we = 1'b0;
        head_wa = cur_bucket;
        head_wd = rd_link_reg;
        head_re = 1'b0;
        head_ra = cur_bucket;
        link_we = 1'b0;
        link_wa = prev_m1[IW-1:0];
        link_wd = rd_link_reg;
        node_re = 1'b0;
        node_ra = head_m1[IW-1:0];
        used_we = 1'b0;
        used_wa = cur_m1[IW-1:0];
        used_wd = 1'b0;
        case (ctrl.op)
            chm_pkg::OP_CLEAR:
            begin
                head_we = 1'b1;
                head_wa = BW'(clr_reg);
                head_wd = '0;
            end
            chm_pkg::OP_ACCEPT:
            begin
                head_re = 1'b1;
                head_ra = req_bucket;
            end
            chm_pkg::OP_HEAD, chm_pkg::OP_G_HDAT:
            begin
                node_re = (head_rd_reg != '0);
            end
            chm_pkg::OP_STEP:
            begin
                node_re = 1'b1;
                node_ra = link_m1[IW-1:0];
            end
            chm_pkg::OP_UNLINK:
            begin
                head_we = (prev_reg == '0);
                link_we = (prev_reg != '0);
                used_we = 1'b1;
            end
            chm_pkg::OP_G_HEAD:
            begin
                head_re = 1'b1;
                head_ra = gb_reg;
            end
            chm_pkg::OP_G_NODE:
            begin
                link_we = 1'b1;
                link_wa = cur_m1[IW-1:0];
                link_wd = tmp_reg[k_idx];
                node_re = (rd_link_reg != '0);
                node_ra = link_m1[IW-1:0];
            end
            chm_pkg::OP_G_WRITE:
            begin
                head_we = 1'b1;
                head_wa = gb_reg | (BW'(wk_reg) << log_reg);
                head_wd = tmp_reg[0];
            end
            chm_pkg::OP_INS_RD:
            begin
                head_re = 1'b1;
            end
            chm_pkg::OP_INS_WR:
            begin
                head_we = 1'b1;
                head_wd = scan_p1;
                link_we = 1'b1;
                link_wa = scan_reg[IW-1:0];
                link_wd = head_rd_reg;
                used_we = 1'b1;
                used_wa = scan_reg[IW-1:0];
                used_wd = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (head_re)
        begin
            head_rd_reg <= head_mem[head_ra];
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        if (ctrl.op == chm_pkg::OP_INS_WR)
        begin
            key_mem[scan_reg[IW-1:0]]  <= key_reg;
            val_mem[scan_reg[IW-1:0]]  <= value_reg;
            hash_mem[scan_reg[IW-1:0]] <= hash_reg;
        end
        if (node_re)
        begin
            rd_key_reg  <= key_mem[node_ra];
            rd_val_reg  <= val_mem[node_ra];
            rd_hash_reg <= hash_mem[node_ra];
            rd_link_reg <= link_mem[node_ra];
        end
        if (ctrl.op == chm_pkg::OP_SCAN_RD)
        begin
            used_rd_reg <= used_mem[scan_reg[IW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            chm_pkg::OP_ACCEPT:
            begin
                cmd_reg   <= req.command;
                key_reg   <= req.key[KB-1:0];
                hash_reg  <= req.key_hash[BW-1:0];
                value_reg <= req.value[VB-1:0];
            end
            chm_pkg::OP_HEAD:
            begin
                cur_reg  <= head_rd_reg;
                prev_reg <= '0;
            end
            chm_pkg::OP_STEP:
            begin
                prev_reg <= cur_reg;
                cur_reg  <= rd_link_reg;
            end
            chm_pkg::OP_SCAN_INIT:
            begin
                scan_reg <= free_low_reg;
            end
            chm_pkg::OP_SCAN_INC:
            begin
                scan_reg <= scan_p1;
            end
            chm_pkg::OP_G_HDAT:
            begin
                cur_reg <= head_rd_reg;
                for (int i = 0; i < 4; i++)
                begin
                    tmp_reg[i] <= '0;
                end
            end
            chm_pkg::OP_G_NODE:
            begin
                tmp_reg[k_idx] <= cur_reg;
                cur_reg        <= rd_link_reg;
            end
            chm_pkg::OP_G_WRITE:
            begin
                tmp_reg[0] <= tmp_reg[1];
                tmp_reg[1] <= tmp_reg[2];
                tmp_reg[2] <= tmp_reg[3];
                tmp_reg[3] <= '0;
            end
            default:
            begin
            end
        endcase
        if (ctrl.op == chm_pkg::OP_RESULT)
        begin
            out_reg.status      <= ctrl.code;
            out_reg.value_out   <= (ctrl.code == chm_pkg::STAT_OK && cmd_reg == chm_pkg::CMD_GET)
                                   ? chm_pkg::FIELD_BITS'(rd_val_reg) : '0;
            out_reg.entry_total <= chm_pkg::TOTAL_BITS'(count_reg);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_reg       <= LW'(chm_pkg::INIT_LOG);
            new_log_reg   <= LW'(chm_pkg::INIT_LOG);
            count_reg     <= '0;
            hw_reg        <= '0;
            free_low_reg  <= '0;
            clr_reg       <= '0;
            gb_reg        <= '0;
            wk_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                chm_pkg::OP_CLEAR:
                begin
                    clr_reg <= clr_reg + IB'(1);
                end
                chm_pkg::OP_UNLINK:
                begin
                    count_reg <= count_reg - NW'(1);
                    if (cur_m1 < free_low_reg)
                    begin
                        free_low_reg <= cur_m1;
                    end
                end
                chm_pkg::OP_GROW_INIT:
                begin
                    new_log_reg <= new_log_next;
                    gb_reg      <= '0;
                    wk_reg      <= '0;
                end
                chm_pkg::OP_G_WRITE:
                begin
                    wk_reg <= wk_reg + 2'd1;
                    if (stat.wk_last)
                    begin
                        wk_reg <= '0;
                        gb_reg <= gb_reg + BW'(1);
                        if (stat.gb_last)
                        begin
                            log_reg <= new_log_reg;
                        end
                    end
                end
                chm_pkg::OP_INS_WR:
                begin
                    count_reg    <= count_reg + NW'(1);
                    free_low_reg <= scan_p1;
                    if (scan_p1 > hw_reg)
                    begin
                        hw_reg <= scan_p1;
                    end
                end
                default:
                begin
                end
            endcase
            if (ctrl.op == chm_pkg::OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(NODE_COUNT))
        else $error("entry count beyond pool size");

    a_count_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hw_reg)
        else $error("more entries than nodes ever written");

    a_free_low_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
        free_low_reg <= hw_reg)
        else $error("free search start beyond written nodes");

    a_log_range: assert property (@(posedge clk) disable iff (!rst_n)
        log_reg <= LW'(LIMIT) && log_reg >= LW'(chm_pkg::INIT_LOG))
        else $error("bucket count out of range");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == chm_pkg::OP_RESULT) |-> out_free)
        else $error("result written over a pending response");

endmodule

`default_nettype wire

### hw/rtl/chm_ctrl.sv
// Controller state machine of the chained hash map.
`default_nettype none

module chm_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                req_valid,
    output logic               req_stall,
    input  chm_pkg::dp_stat_t  stat,
    output chm_pkg::ctrl_t     ctrl
);

    chm_pkg::state_t state_reg;
    chm_pkg::state_t state_next;
    logic [1:0]      code_reg;
    logic [1:0]      code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::ST_CLEAR;
            code_reg  <= chm_pkg::STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chm_pkg::ST_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = chm_pkg::ST_IDLE;
                end
            end
            chm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = chm_pkg::ST_HEAD;
                end
            end
            chm_pkg::ST_HEAD:
            begin
                state_next = stat.head_zero ? chm_pkg::ST_MISS : chm_pkg::ST_NODE;
            end
            chm_pkg::ST_NODE:
            begin
                if (stat.key_match)
                begin
                    state_next = chm_pkg::ST_RESP;
                end
                else if (stat.link_zero)
                begin
                    state_next = chm_pkg::ST_MISS;
                end
            end
            chm_pkg::ST_MISS:
            begin
                if (stat.command == chm_pkg::CMD_INSERT && !stat.pool_full)
                begin
                    state_next = chm_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = chm_pkg::ST_RESP;
                end
            end
            chm_pkg::ST_SCAN:
            begin
                state_next = stat.scan_at_hw ? chm_pkg::ST_GROW_CHK : chm_pkg::ST_SCAN_CHK;
            end
            chm_pkg::ST_SCAN_CHK:
            begin
                state_next = stat.used_bit ? chm_pkg::ST_SCAN : chm_pkg::ST_GROW_CHK;
            end
            chm_pkg::ST_GROW_CHK:
            begin
                state_next = stat.grow_need ? chm_pkg::ST_G_HEAD : chm_pkg::ST_INS_RD;
            end
            chm_pkg::ST_G_HEAD:
            begin
                state_next = chm_pkg::ST_G_HDAT;
            end
            chm_pkg::ST_G_HDAT:
            begin
                state_next = chm_pkg::ST_G_NODE;
            end
            chm_pkg::ST_G_NODE:
            begin
                if (stat.cur_zero)
                begin
                    state_next = chm_pkg::ST_G_WRITE;
                end
            end
            chm_pkg::ST_G_WRITE:
            begin
                if (stat.wk_last)
                begin
                    state_next = stat.gb_last ? chm_pkg::ST_INS_RD : chm_pkg::ST_G_HEAD;
                end
            end
            chm_pkg::ST_INS_RD:
            begin
                state_next = chm_pkg::ST_INS_WR;
            end
            chm_pkg::ST_INS_WR:
            begin
                state_next = chm_pkg::ST_RESP;
            end
            chm_pkg::ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = chm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands and the status code of the request.
    always_comb
    begin
        ctrl.op   = chm_pkg::OP_NONE;
        ctrl.code = code_reg;
        code_next = code_reg;
        case (state_reg)
            chm_pkg::ST_CLEAR:
            begin
                ctrl.op = chm_pkg::OP_CLEAR;
            end
            chm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.op = chm_pkg::OP_ACCEPT;
                end
            end
            chm_pkg::ST_HEAD:
            begin
                if (!stat.head_zero)
                begin
                    ctrl.op = chm_pkg::OP_HEAD;
                end
            end
            chm_pkg::ST_NODE:
            begin
                if (stat.key_match)
                begin
                    case (stat.command)
                        chm_pkg::CMD_INSERT:
                        begin
                            code_next = chm_pkg::STAT_DUP;
                        end
                        chm_pkg::CMD_REMOVE:
                        begin
                            ctrl.op   = chm_pkg::OP_UNLINK;
                            code_next = chm_pkg::STAT_OK;
                        end
                        chm_pkg::CMD_GET:
                        begin
                            code_next = chm_pkg::STAT_OK;
                        end
                        default:
                        begin
                            code_next = chm_pkg::STAT_NOTFOUND;
                        end
                    endcase
                end
                else if (!stat.link_zero)
                begin
                    ctrl.op = chm_pkg::OP_STEP;
                end
            end
            chm_pkg::ST_MISS:
            begin
                if (stat.command != chm_pkg::CMD_INSERT)
                begin
                    code_next = chm_pkg::STAT_NOTFOUND;
                end
                else if (stat.pool_full)
                begin
                    code_next = chm_pkg::STAT_FULL;
                end
                else
                begin
                    ctrl.op = chm_pkg::OP_SCAN_INIT;
                end
            end
            chm_pkg::ST_SCAN:
            begin
                if (!stat.scan_at_hw)
                begin
                    ctrl.op = chm_pkg::OP_SCAN_RD;
                end
            end
            chm_pkg::ST_SCAN_CHK:
            begin
                if (stat.used_bit)
                begin
                    ctrl.op = chm_pkg::OP_SCAN_INC;
                end
            end
            chm_pkg::ST_GROW_CHK:
            begin
                if (stat.grow_need)
                begin
                    ctrl.op = chm_pkg::OP_GROW_INIT;
                end
            end
            chm_pkg::ST_G_HEAD:
            begin
                ctrl.op = chm_pkg::OP_G_HEAD;
            end
            chm_pkg::ST_G_HDAT:
            begin
                ctrl.op = chm_pkg::OP_G_HDAT;
            end
            chm_pkg::ST_G_NODE:
            begin
                if (!stat.cur_zero)
                begin
                    ctrl.op = chm_pkg::OP_G_NODE;
                end
            end
            chm_pkg::ST_G_WRITE:
            begin
                ctrl.op = chm_pkg::OP_G_WRITE;
            end
            chm_pkg::ST_INS_RD:
            begin
                ctrl.op = chm_pkg::OP_INS_RD;
            end
            chm_pkg::ST_INS_WR:
            begin
                ctrl.op   = chm_pkg::OP_INS_WR;
                code_next = chm_pkg::STAT_OK;
            end
            chm_pkg::ST_RESP:
            begin
                if (stat.out_free)
                begin
                    ctrl.op = chm_pkg::OP_RESULT;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req_stall = (state_reg != chm_pkg::ST_IDLE);

endmodule

`default_nettype wire

### hw/rtl/chained_hash_map.sv
// Chained hash map: a key-value store with separate chaining over a fixed node pool.
//
// A request on req carries a command (insert, remove, get), a key, the key's hash and a
// value; it is taken when req_valid is high and req_stall low. Exactly one response
// leaves on rsp with a status, the value found by a get and the entry count after the
// command; it is taken when rsp_valid is high and rsp_stall low.
// One request is in work at a time. A lookup reads the bucket head and walks the
// chain node by node, with one more step when the key is absent; a final step loads the
// response register. An insert of a new key adds the free-node search (passing over
// used nodes, usually none, and reusing a freed node) and the linking of the node. When
// the load passes 1.5 entries per bucket, the insert first rebuilds the chains: each
// old bucket is read and its entries are spread over the new buckets.
// After reset the four initial buckets are cleared, one per cycle, while req_stall is
// high; the map is then empty. While rsp_stall holds a response, the next request is
// still taken and worked up to its own response, which waits for the register to free.
`default_nettype none

module chained_hash_map #(
    parameter int NODE_COUNT  = 1024,
    parameter int MAX_BUCKETS = 4096,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_stall,
    input  chm_pkg::req_t  req,
    output logic           rsp_valid,
    input  wire            rsp_stall,
    output chm_pkg::rsp_t  rsp
);

    chm_pkg::ctrl_t    ctrl;
    chm_pkg::dp_stat_t stat;

    chm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    chm_datapath #(
        .NODE_COUNT  (NODE_COUNT),
        .MAX_BUCKETS (MAX_BUCKETS),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctrl      (ctrl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

### test/chm_checker.sv
// Checker for the chained hash map: predicts each response and compares it.
`default_nettype none

module chm_checker #(
    parameter int NODE_COUNT  = 1024,
    parameter int MAX_BUCKETS = 4096
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    input  wire            req_stall,
    input  chm_pkg::req_t  req,
    input  wire            rsp_valid,
    input  wire            rsp_stall,
    input  chm_pkg::rsp_t  rsp,
    output int             fail_count,
    output int             pending
);

    logic [10:0]   heads [MAX_BUCKETS];
    logic [10:0]   regrow [MAX_BUCKETS];
    logic [31:0]   keys [NODE_COUNT];
    logic [31:0]   vals [NODE_COUNT];
    logic [31:0]   hashes [NODE_COUNT];
    logic [10:0]   links [NODE_COUNT];
    bit            used [NODE_COUNT];
    int            count;
    int            blog;
    int            blimit;
    chm_pkg::rsp_t due_q [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
        for (int b = 0; b < MAX_BUCKETS; b++)
            heads[b] = '0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            used[i] = 0;
            links[i] = '0;
        end
        count = 0;
        blog = chm_pkg::INIT_LOG;
        blimit = chm_pkg::INIT_LOG;
        while ((64'd1 << (blimit + 1)) <= MAX_BUCKETS)
            blimit++;
    end

    function automatic int bucket_of(logic [31:0] h);
        return int'(h & ((32'd1 << blog) - 1));
    endfunction

    function automatic int lookup(logic [31:0] k, logic [31:0] h);
        int cur;
        cur = heads[bucket_of(h)];
        while (cur != 0)
        begin
            if (keys[cur-1] == k)
                return cur;
            cur = links[cur-1];
        end
        return 0;
    endfunction

    task automatic regrow_table();
        int old_n;
        int nlog;
        int cur;
        int nxt;
        int nb;
        old_n = 1 << blog;
        nlog = blog + ((old_n < 512) ? 2 : 1);
        if (nlog > blimit)
            nlog = blimit;
        if (nlog <= blog)
            return;
        for (int b = 0; b < MAX_BUCKETS; b++)
            regrow[b] = '0;
        for (int b = 0; b < old_n; b++)
        begin
            cur = heads[b];
            while (cur != 0)
            begin
                nxt = links[cur-1];
                nb = int'(hashes[cur-1] & ((32'd1 << nlog) - 1));
                links[cur-1] = regrow[nb];
                regrow[nb] = cur[10:0];
                cur = nxt;
            end
        end
        heads = regrow;
        blog = nlog;
    endtask

    task automatic apply_request(chm_pkg::req_t r);
        chm_pkg::rsp_t o;
        int hit;
        int i;
        int b;
        int prev;
        int cur;
        o = '0;
        o.status = chm_pkg::STAT_NOTFOUND;
        case (r.command)
            chm_pkg::CMD_INSERT:
            begin
                if (lookup(r.key, r.key_hash) != 0)
                    o.status = chm_pkg::STAT_DUP;
                else
                begin
                    i = 0;
                    while (i < NODE_COUNT && used[i])
                        i++;
                    if (i >= NODE_COUNT)
                        o.status = chm_pkg::STAT_FULL;
                    else
                    begin
                        if (longint'(count) * 2 > (longint'(3) << blog))
                            regrow_table();
                        b = bucket_of(r.key_hash);
                        keys[i] = r.key;
                        vals[i] = r.value;
                        hashes[i] = r.key_hash;
                        links[i] = heads[b];
                        used[i] = 1;
                        heads[b] = 11'(i + 1);
                        count++;
                        o.status = chm_pkg::STAT_OK;
                    end
                end
            end
            chm_pkg::CMD_REMOVE:
            begin
                b = bucket_of(r.key_hash);
                prev = 0;
                cur = heads[b];
                while (cur != 0)
                begin
                    if (keys[cur-1] == r.key)
                    begin
                        if (prev == 0)
                            heads[b] = links[cur-1];
                        else
                            links[prev-1] = links[cur-1];
                        used[cur-1] = 0;
                        links[cur-1] = '0;
                        count--;
                        o.status = chm_pkg::STAT_OK;
                        break;
                    end
                    prev = cur;
                    cur = links[cur-1];
                end
            end
            chm_pkg::CMD_GET:
            begin
                hit = lookup(r.key, r.key_hash);
                if (hit != 0)
                begin
                    o.status = chm_pkg::STAT_OK;
                    o.value_out = vals[hit-1];
                end
            end
            default:
            begin
            end
        endcase
        o.entry_total = 11'(count);
        due_q.push_back(o);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        chm_pkg::rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                apply_request(req);
            if (rsp_valid && !rsp_stall)
            begin
                if (due_q.size() == 0)
                    report("unexpected response", 32'(rsp), 32'd0);
                else
                begin
                    want = due_q.pop_front();
                    if (rsp.status !== want.status)
                        report("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.value_out !== want.value_out)
                        report("value_out", rsp.value_out, want.value_out);
                    if (rsp.entry_total !== want.entry_total)
                        report("entry_total", 32'(rsp.entry_total), 32'(want.entry_total));
                end
            end
            pending = due_q.size();
        end
    end

endmodule

`default_nettype wire

### test/tb_top.sv
// Top of the chained hash map testbench: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;

    localparam int WATCH_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    chm_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    chm_pkg::rsp_t rsp;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   hold_long;
    bit   stim_done;
    logic [31:0] pool_keys [64];

    chained_hash_map u_top (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    chm_checker u_chk (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Hash used for most keys, spread well over the buckets.
    function automatic logic [31:0] mix(logic [31:0] k);
        return k * 32'h9E37_79B1;
    endfunction

    // Sends one request, inserting a random gap before it.
    task automatic send(logic [1:0] cmd, logic [31:0] k, logic [31:0] h, logic [31:0] v);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req_valid <= 1'b1;
        req.command <= cmd;
        req.key <= k;
        req.key_hash <= h;
        req.value <= v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, and one long hold-off while the pool is being filled.
    initial
    begin
        int g;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                hold_long = 0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            g = gap_len();
            if (g != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (g) @(negedge clk);
            end
            rsp_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] k;
        logic [1:0]  c;
        idle_cycles = 0;
        hold_long = 0;
        stim_done = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        for (int i = 0; i < 64; i++)
            pool_keys[i] = $urandom();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: misses on an empty map, extremes, duplicates, unknown command.
        send(chm_pkg::CMD_GET, 32'h0, 32'h0, 32'h0);
        send(chm_pkg::CMD_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
        send(chm_pkg::CMD_INSERT, 32'h0, 32'h0, 32'hFFFFFFFF);
        send(chm_pkg::CMD_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
        send(chm_pkg::CMD_INSERT, 32'h0, 32'h0, 32'h1234);
        send(chm_pkg::CMD_INSERT, 32'h5, 32'h0, 32'hA5A5A5A5);
        send(chm_pkg::CMD_INSERT, 32'h9, 32'h4, 32'h5A5A5A5A);
        send(chm_pkg::CMD_GET, 32'h0, 32'h0, 32'h0);
        send(chm_pkg::CMD_GET, 32'h5, 32'h0, 32'h0);
        send(chm_pkg::CMD_GET, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(chm_pkg::CMD_REMOVE, 32'h5, 32'h0, 32'h0);
        send(chm_pkg::CMD_GET, 32'h9, 32'h4, 32'h0);
        send(chm_pkg::CMD_REMOVE, 32'h0, 32'h0, 32'h0);
        send(chm_pkg::CMD_REMOVE, 32'h0, 32'h0, 32'h0);
        send(CMD_UNKNOWN, 32'h9, 32'h4, 32'h0);
        send(chm_pkg::CMD_INSERT, 32'h7, 32'h1, 32'h77);
        send(chm_pkg::CMD_INSERT, 32'h8, 32'h2, 32'h88);
        send(chm_pkg::CMD_GET, 32'h9, 32'h0, 32'h0);

        // Fill the pool completely to reach the full case and the growth steps.
        for (int i = 0; i < 1030; i++)
        begin
            k = 32'h8000_0000 + i;
            send(chm_pkg::CMD_INSERT, k, mix(k), 32'(i));
            if (i == 40)
                hold_long = 1;
        end
        send(chm_pkg::CMD_INSERT, 32'h7FFF_FFFF, $urandom(), 32'h1);

        // Random part over a small key pool and the stored keys, hash mostly from the key.
        for (int i = 0; i < 150; i++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    k = $urandom();
                end
                1:
                begin
                    k = pool_keys[$urandom_range(0, 63)];
                end
                default:
                begin
                    k = 32'h8000_0000 + $urandom_range(0, 1029);
                end
            endcase
            c = ($urandom_range(0, 40) == 0) ? CMD_UNKNOWN : 2'($urandom_range(0, 2));
            send(c, k, ($urandom_range(0, 19) == 0) ? $urandom() : mix(k), $urandom());
        end
        req_valid <= 1'b0;
        stim_done = 1;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered empty-map misses, duplicates, unknown commands, a full pool and");
        $display("growth up to 1024 buckets, then mixed traffic with removals and refills.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
